// ===== design/cna_pkg.sv =====
// Shared constants, types and helper functions of the advection step block.
`timescale 1ns / 1ps

package cna_pkg;

    // Sizes of the grid and of the sample format.
    localparam int MAX_POINTS = 64;
    localparam int MIN_POINTS = 3;
    localparam int SAMPLE_W   = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int FRAC_W     = 16;

    // Coefficient, factor and diagonal widths.
    localparam int COEF_W = 20;
    localparam int LF_W   = COEF_W + 1;
    localparam int DIAG_W = 25;
    localparam int CSQ_W  = 2 * COEF_W;

    // Shared multiplier: signed operand A times signed operand K.
    localparam int MA_W   = SAMPLE_W + 1;
    localparam int MK_W   = LF_W;
    localparam int PROD_W = MA_W + MK_W;
    localparam int MUL_W  = PROD_W - FRAC_W + 1;
    localparam int WIDE_W = MUL_W + 1;

    // Shared divider: dividend and divisor widths.
    localparam int NUM_W  = 36;
    localparam int DVD_W  = NUM_W + FRAC_W;
    localparam int DVS_W  = DIAG_W;
    localparam int DCNT_W = $clog2(DVD_W);

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [COEF_W-1:0] COEF_RESET   = COEF_W'(8192);
    localparam logic [CNT_W-1:0]  POINTS_RESET = CNT_W'(MAX_POINTS);
    localparam logic [DIAG_W-1:0] ONE_Q16      = DIAG_W'(65536);

    // Register index, taken from the word address.
    typedef enum logic [ADDR_W-3:0] {
        REG_COEFF  = 1'b0,
        REG_POINTS = 1'b1
    } reg_idx_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PRE_LEFT,
        ST_PRE_CUR,
        ST_PRE_INIT,
        ST_F_READ,
        ST_F_DIFF,
        ST_F_Q,
        ST_F_Y,
        ST_F_DIVL,
        ST_F_DIVD,
        ST_B_READ,
        ST_B_DIV,
        ST_B_WAIT,
        ST_E_READ,
        ST_E_LOAD,
        ST_E_WAIT
    } state_t;

    // Saturate a wide signed value to one sample.
    function automatic logic [SAMPLE_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
        lo = -hi - WIDE_W'(1);
        if (v > hi)
            return hi[SAMPLE_W-1:0];
        else if (v < lo)
            return lo[SAMPLE_W-1:0];
        else
            return v[SAMPLE_W-1:0];
    endfunction

    // Saturate a quotient magnitude with a sign to one sample.
    function automatic logic [SAMPLE_W-1:0] sat_mag(input logic neg,
                                                   input logic [DVD_W-1:0] mag);
        logic [DVD_W-1:0] lim;
        lim = DVD_W'(1) << (SAMPLE_W - 1);
        if (neg)
            return (mag >= lim) ? lim[SAMPLE_W-1:0] : SAMPLE_W'(~mag + DVD_W'(1));
        else
            return (mag >= lim) ? SAMPLE_W'(lim - DVD_W'(1)) : mag[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== design/cna_in_if.sv =====
// Stream interfaces for the sample input and the result output.
`timescale 1ns / 1ps

interface cna_in_if;
    logic                           valid;
    logic                           ready;
    logic [cna_pkg::SAMPLE_W-1:0]   sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface cna_out_if;
    logic                           valid;
    logic                           ready;
    logic [cna_pkg::SAMPLE_W-1:0]   sample_out;
    logic                           last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink (input valid, input sample_out, input last_out, output ready);
endinterface

// ===== design/crank_nicolson_advection_step.sv =====
// Top level: one Crank-Nicolson advection step over a loaded wave.
//
//   Channel   Kind         Beat contents
//   load      stream in    sample_in (signed Q16.16, grid order)
//   emit      stream out   sample_out (signed Q16.16, saturated), last_out
//   APB       config       advection_coeff at 0x0, points_in_use at 0x4
//
// Loading accepts one sample per cycle. Once the last sample of a wave of N points
// arrives, the block solves the system, its run time dominated by
// the shared one-bit-per-cycle divider (two divisions per factor step, one per
// backward step), then emits N beats, each held until emit takes it.
// load.ready is low from the final sample until the last beat has been taken.
// Reset clears the sequencer and the load count; stores hold no reset value.
`timescale 1ns / 1ps

module crank_nicolson_advection_step (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cna_pkg::ADDR_W-1:0]   paddr,
    input  logic [cna_pkg::DATA_W-1:0]   pwdata,
    output logic [cna_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    cna_in_if.sink                       load,
    cna_out_if.source                    emit
);

    // Configuration registers.
    logic [cna_pkg::COEF_W-1:0]  coef_reg;
    logic [cna_pkg::CNT_W-1:0]   points_reg;
    logic                        cfg_wr;
    cna_pkg::reg_idx_t           cfg_idx;

    // Sequencer and counters.
    cna_pkg::state_t             state_reg;
    cna_pkg::state_t             state_next;
    logic [cna_pkg::CNT_W-1:0]   load_count_reg;
    logic [cna_pkg::CNT_W-1:0]   load_count_next;
    logic [cna_pkg::IDX_W-1:0]   idx_reg;
    logic [cna_pkg::IDX_W-1:0]   idx_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    // Datapath registers.
    logic [cna_pkg::SAMPLE_W-1:0] w_left_reg,  w_left_next;
    logic [cna_pkg::SAMPLE_W-1:0] w_cur_reg,   w_cur_next;
    logic [cna_pkg::SAMPLE_W-1:0] w_right_reg, w_right_next;
    logic [cna_pkg::SAMPLE_W-1:0] q_reg,       q_next;
    logic [cna_pkg::SAMPLE_W-1:0] y_prev_reg,  y_prev_next;
    logic [cna_pkg::SAMPLE_W-1:0] x_next_reg,  x_next_next;
    logic [cna_pkg::LF_W-1:0]     l_prev_reg,  l_prev_next;
    logic [cna_pkg::DIAG_W-1:0]   d_cur_reg,   d_cur_next;
    logic [cna_pkg::CSQ_W-1:0]    csq_reg,     csq_next;
    logic [cna_pkg::MUL_W-1:0]    m_reg,       m_next;
    logic                         neg_reg,     neg_next;
    logic [cna_pkg::SAMPLE_W-1:0] out_data_reg, out_data_next;
    logic                         out_last_reg, out_last_next;

    // Derived point count.
    logic [cna_pkg::CNT_W-1:0]   n_cnt;
    logic [cna_pkg::IDX_W-1:0]   n_last;
    logic [cna_pkg::IDX_W-1:0]   load_idx;
    logic                        load_beat;
    logic                        emit_beat;

    // Shared multiplier.
    logic signed [cna_pkg::MA_W-1:0]   mul_a;
    logic signed [cna_pkg::MK_W-1:0]   mul_k;
    logic [cna_pkg::MA_W-1:0]          mul_a_mag;
    logic [cna_pkg::MK_W-1:0]          mul_k_mag;
    logic [cna_pkg::PROD_W-1:0]        mul_prod;
    logic [cna_pkg::MUL_W-1:0]         mul_shift;
    logic [cna_pkg::MUL_W-1:0]         mul_res;

    // Shared divider.
    logic                        div_start;
    logic [cna_pkg::DVD_W-1:0]   div_dvd;
    logic [cna_pkg::DVS_W-1:0]   div_dvs;
    logic                        div_done;
    logic [cna_pkg::DVD_W-1:0]   div_quo;

    // Memories.
    logic                        wave_we;
    logic [cna_pkg::IDX_W-1:0]   wave_raddr;
    logic [cna_pkg::SAMPLE_W-1:0] wave_rdata;
    logic                        fs_we;
    logic [cna_pkg::SAMPLE_W-1:0] fs_wdata;
    logic [cna_pkg::SAMPLE_W-1:0] fwd_rdata;
    logic [cna_pkg::DIAG_W-1:0]  diag_rdata;
    logic                        sol_we;
    logic [cna_pkg::SAMPLE_W-1:0] sol_wdata;
    logic [cna_pkg::SAMPLE_W-1:0] sol_rdata;

    // Wide intermediate values.
    logic signed [cna_pkg::WIDE_W-1:0] wide_diff;
    logic signed [cna_pkg::WIDE_W-1:0] back_num;
    logic [cna_pkg::WIDE_W-1:0]        back_abs;

    // Configuration port: writes land on the access beat, pready always high.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cna_pkg::reg_idx_t'(paddr[cna_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg   <= cna_pkg::COEF_RESET;
            points_reg <= cna_pkg::POINTS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                cna_pkg::REG_COEFF:  coef_reg   <= pwdata[cna_pkg::COEF_W-1:0];
                cna_pkg::REG_POINTS: points_reg <= pwdata[cna_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            cna_pkg::REG_COEFF:  prdata = cna_pkg::DATA_W'(coef_reg);
            cna_pkg::REG_POINTS: prdata = cna_pkg::DATA_W'(points_reg);
            default:             prdata = '0;
        endcase
    end

    // Point count clamped to the supported range.
    always_comb
    begin
        if (points_reg < cna_pkg::CNT_W'(cna_pkg::MIN_POINTS))
            n_cnt = cna_pkg::CNT_W'(cna_pkg::MIN_POINTS);
        else if (points_reg > cna_pkg::CNT_W'(cna_pkg::MAX_POINTS))
            n_cnt = cna_pkg::CNT_W'(cna_pkg::MAX_POINTS);
        else
            n_cnt = points_reg;
    end

    assign n_last   = cna_pkg::IDX_W'(n_cnt - cna_pkg::CNT_W'(1));
    assign load_idx = (load_count_reg >= n_cnt) ? n_last
                                                : load_count_reg[cna_pkg::IDX_W-1:0];

    // Handshakes.
    assign load.ready   = (state_reg == cna_pkg::ST_IDLE);
    assign load_beat    = load.valid && (state_reg == cna_pkg::ST_IDLE);
    assign emit.valid   = out_valid_reg;
    assign emit.sample_out = out_data_reg;
    assign emit.last_out   = out_last_reg;
    assign emit_beat    = out_valid_reg && emit.ready;

    // Shared multiplier: operands chosen by the sequencer, product scaled by 2^-16
    // and truncated toward zero.
    always_comb
    begin
        mul_a = '0;
        mul_k = '0;
        unique case (state_reg)
            cna_pkg::ST_PRE_INIT:
            begin
                mul_a = cna_pkg::MA_W'(coef_reg);
                mul_k = cna_pkg::MK_W'(coef_reg);
            end
            cna_pkg::ST_F_DIFF:
            begin
                mul_a = cna_pkg::MA_W'(signed'(wave_rdata)) - cna_pkg::MA_W'(signed'(w_left_reg));
                mul_k = cna_pkg::MK_W'(coef_reg);
            end
            cna_pkg::ST_F_Q:
            begin
                mul_a = cna_pkg::MA_W'(signed'(y_prev_reg));
                mul_k = signed'(l_prev_reg);
            end
            cna_pkg::ST_B_READ:
            begin
                mul_a = cna_pkg::MA_W'(signed'(x_next_reg));
                mul_k = cna_pkg::MK_W'(coef_reg);
            end
            default: ;
        endcase
        mul_a_mag = mul_a[cna_pkg::MA_W-1] ? cna_pkg::MA_W'(-mul_a) : cna_pkg::MA_W'(mul_a);
        mul_k_mag = mul_k[cna_pkg::MK_W-1] ? cna_pkg::MK_W'(-mul_k) : cna_pkg::MK_W'(mul_k);
        mul_prod  = cna_pkg::PROD_W'(mul_a_mag) * cna_pkg::PROD_W'(mul_k_mag);
        mul_shift = cna_pkg::MUL_W'(mul_prod[cna_pkg::PROD_W-1:cna_pkg::FRAC_W]);
        mul_res   = (mul_a[cna_pkg::MA_W-1] ^ mul_k[cna_pkg::MK_W-1]) ? -mul_shift : mul_shift;
    end

    // Differences formed from the registered product.
    always_comb
    begin
        unique case (state_reg)
            cna_pkg::ST_F_Q:
                wide_diff = cna_pkg::WIDE_W'(signed'(w_cur_reg)) - cna_pkg::WIDE_W'(signed'(m_reg));
            default:
                wide_diff = cna_pkg::WIDE_W'(signed'(q_reg)) - cna_pkg::WIDE_W'(signed'(m_reg));
        endcase
        back_num = cna_pkg::WIDE_W'(signed'(fwd_rdata)) - cna_pkg::WIDE_W'(signed'(m_reg));
        back_abs = back_num[cna_pkg::WIDE_W-1] ? cna_pkg::WIDE_W'(-back_num)
                                              : cna_pkg::WIDE_W'(back_num);
    end

    // Sequencer: next state, datapath updates and unit controls.
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        w_left_next     = w_left_reg;
        w_cur_next      = w_cur_reg;
        w_right_next    = w_right_reg;
        q_next          = q_reg;
        y_prev_next     = y_prev_reg;
        x_next_next     = x_next_reg;
        l_prev_next     = l_prev_reg;
        d_cur_next      = d_cur_reg;
        csq_next        = csq_reg;
        m_next          = m_reg;
        neg_next        = neg_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        wave_we         = 1'b0;
        wave_raddr      = idx_reg;
        fs_we           = 1'b0;
        fs_wdata        = cna_pkg::sat_wide(wide_diff);
        sol_we          = 1'b0;
        sol_wdata       = cna_pkg::sat_mag(neg_reg, div_quo);
        div_start       = 1'b0;
        div_dvd         = cna_pkg::DVD_W'({back_abs[cna_pkg::NUM_W-1:0],
                                           cna_pkg::FRAC_W'(0)});
        div_dvs         = diag_rdata;

        unique case (state_reg)
            cna_pkg::ST_IDLE:
            begin
                if (load_beat)
                begin
                    wave_we = 1'b1;
                    if (load_idx == n_last)
                    begin
                        load_count_next = '0;
                        state_next      = cna_pkg::ST_PRE_LEFT;
                    end
                    else
                    begin
                        load_count_next = cna_pkg::CNT_W'(load_idx) + cna_pkg::CNT_W'(1);
                    end
                end
            end

            // Fetch the wrapped left neighbor and the first sample.
            cna_pkg::ST_PRE_LEFT:
            begin
                wave_raddr = n_last;
                state_next = cna_pkg::ST_PRE_CUR;
            end
            cna_pkg::ST_PRE_CUR:
            begin
                wave_raddr  = '0;
                w_left_next = wave_rdata;
                state_next  = cna_pkg::ST_PRE_INIT;
            end
            cna_pkg::ST_PRE_INIT:
            begin
                w_cur_next  = wave_rdata;
                d_cur_next  = cna_pkg::ONE_Q16;
                idx_next    = '0;
                y_prev_next = '0;
                l_prev_next = '0;
                csq_next    = mul_prod[cna_pkg::CSQ_W-1:0];
                state_next  = cna_pkg::ST_F_READ;
            end

            // Forward sweep: right-hand side, factorization and substitution.
            cna_pkg::ST_F_READ:
            begin
                wave_raddr = (idx_reg == n_last) ? '0 : idx_reg + cna_pkg::IDX_W'(1);
                state_next = cna_pkg::ST_F_DIFF;
            end
            cna_pkg::ST_F_DIFF:
            begin
                w_right_next = wave_rdata;
                m_next       = mul_res;
                state_next   = cna_pkg::ST_F_Q;
            end
            cna_pkg::ST_F_Q:
            begin
                q_next     = cna_pkg::sat_wide(wide_diff);
                m_next     = mul_res;
                state_next = cna_pkg::ST_F_Y;
            end
            cna_pkg::ST_F_Y:
            begin
                fs_we       = 1'b1;
                y_prev_next = fs_wdata;
                if (idx_reg == n_last)
                begin
                    x_next_next = '0;
                    state_next  = cna_pkg::ST_B_READ;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = cna_pkg::DVD_W'({coef_reg, cna_pkg::FRAC_W'(0)});
                    div_dvs    = d_cur_reg;
                    state_next = cna_pkg::ST_F_DIVL;
                end
            end
            cna_pkg::ST_F_DIVL:
            begin
                if (div_done)
                begin
                    l_prev_next = cna_pkg::LF_W'(-div_quo);
                    div_start   = 1'b1;
                    div_dvd     = cna_pkg::DVD_W'(csq_reg);
                    div_dvs     = d_cur_reg;
                    state_next  = cna_pkg::ST_F_DIVD;
                end
            end
            cna_pkg::ST_F_DIVD:
            begin
                if (div_done)
                begin
                    d_cur_next  = cna_pkg::ONE_Q16 + cna_pkg::DIAG_W'(div_quo);
                    w_left_next = w_cur_reg;
                    w_cur_next  = w_right_reg;
                    idx_next    = idx_reg + cna_pkg::IDX_W'(1);
                    state_next  = cna_pkg::ST_F_READ;
                end
            end

            // Backward sweep: divide by the diagonal, last point first.
            cna_pkg::ST_B_READ:
            begin
                m_next     = mul_res;
                state_next = cna_pkg::ST_B_DIV;
            end
            cna_pkg::ST_B_DIV:
            begin
                neg_next   = back_num[cna_pkg::WIDE_W-1];
                div_start  = 1'b1;
                state_next = cna_pkg::ST_B_WAIT;
            end
            cna_pkg::ST_B_WAIT:
            begin
                if (div_done)
                begin
                    sol_we      = 1'b1;
                    x_next_next = sol_wdata;
                    if (idx_reg == '0)
                    begin
                        state_next = cna_pkg::ST_E_READ;
                    end
                    else
                    begin
                        idx_next   = idx_reg - cna_pkg::IDX_W'(1);
                        state_next = cna_pkg::ST_B_READ;
                    end
                end
            end

            // Emit the new wave in grid order.
            cna_pkg::ST_E_READ:
            begin
                state_next = cna_pkg::ST_E_LOAD;
            end
            cna_pkg::ST_E_LOAD:
            begin
                out_data_next  = sol_rdata;
                out_last_next  = (idx_reg == n_last);
                out_valid_next = 1'b1;
                state_next     = cna_pkg::ST_E_WAIT;
            end
            cna_pkg::ST_E_WAIT:
            begin
                if (emit_beat)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = cna_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + cna_pkg::IDX_W'(1);
                        state_next = cna_pkg::ST_E_READ;
                    end
                end
            end

            default:
            begin
                state_next = cna_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cna_pkg::ST_IDLE;
            load_count_reg <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        w_left_reg   <= w_left_next;
        w_cur_reg    <= w_cur_next;
        w_right_reg  <= w_right_next;
        q_reg        <= q_next;
        y_prev_reg   <= y_prev_next;
        x_next_reg   <= x_next_next;
        l_prev_reg   <= l_prev_next;
        d_cur_reg    <= d_cur_next;
        csq_reg      <= csq_next;
        m_reg        <= m_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Shared divider.
    cna_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Loaded samples.
    cna_ram #(
        .WIDTH (cna_pkg::SAMPLE_W),
        .DEPTH (cna_pkg::MAX_POINTS)
    ) u_wave (
        .clk   (clk),
        .we    (wave_we),
        .waddr (load_idx),
        .wdata (load.sample_in),
        .raddr (wave_raddr),
        .rdata (wave_rdata)
    );

    // Diagonal of the factorization.
    cna_ram #(
        .WIDTH (cna_pkg::DIAG_W),
        .DEPTH (cna_pkg::MAX_POINTS)
    ) u_diag (
        .clk   (clk),
        .we    (fs_we),
        .waddr (idx_reg),
        .wdata (d_cur_reg),
        .raddr (idx_reg),
        .rdata (diag_rdata)
    );

    // Forward substitution values.
    cna_ram #(
        .WIDTH (cna_pkg::SAMPLE_W),
        .DEPTH (cna_pkg::MAX_POINTS)
    ) u_fwd (
        .clk   (clk),
        .we    (fs_we),
        .waddr (idx_reg),
        .wdata (fs_wdata),
        .raddr (idx_reg),
        .rdata (fwd_rdata)
    );

    // New samples.
    cna_ram #(
        .WIDTH (cna_pkg::SAMPLE_W),
        .DEPTH (cna_pkg::MAX_POINTS)
    ) u_sol (
        .clk   (clk),
        .we    (sol_we),
        .waddr (idx_reg),
        .wdata (sol_wdata),
        .raddr (idx_reg),
        .rdata (sol_rdata)
    );

endmodule

// ===== design/cna_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== design/cna_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps

module cna_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cna_pkg::DVD_W-1:0]   dividend,
    input  logic [cna_pkg::DVS_W-1:0]   divisor,
    output logic                        done,
    output logic [cna_pkg::DVD_W-1:0]   quotient
);

    logic                        busy_reg;
    logic                        busy_next;
    logic                        done_reg;
    logic                        done_next;
    logic [cna_pkg::DCNT_W-1:0]  cnt_reg;
    logic [cna_pkg::DCNT_W-1:0]  cnt_next;
    logic [cna_pkg::DVS_W-1:0]   rem_reg;
    logic [cna_pkg::DVS_W-1:0]   rem_next;
    logic [cna_pkg::DVD_W-1:0]   quo_reg;
    logic [cna_pkg::DVD_W-1:0]   quo_next;
    logic [cna_pkg::DVS_W-1:0]   den_reg;
    logic [cna_pkg::DVS_W-1:0]   den_next;
    logic [cna_pkg::DVS_W:0]     trial;
    logic                        fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[cna_pkg::DVD_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = cna_pkg::DCNT_W'(cna_pkg::DVD_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? cna_pkg::DVS_W'(trial - {1'b0, den_reg})
                            : trial[cna_pkg::DVS_W-1:0];
            quo_next = {quo_reg[cna_pkg::DVD_W-2:0], fits};
            cnt_next = cnt_reg - cna_pkg::DCNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
